>>> sv/xml_escape_utf8_validate_core_assert.svh
// assertion macros used by the escaper back end
`ifndef XML_ESCAPE_UTF8_VALIDATE_CORE_ASSERT_SVH
`define XML_ESCAPE_UTF8_VALIDATE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define XEV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xev assertion failed");
`define XEV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xev assertion failed");
`else
`define XEV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XEV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/xev_pkg.sv
// types, action codes and escape tables for the xml escaper
package xev_pkg;

  typedef logic [2:0] act_t;

  localparam act_t ACT_BYTE = 3'd0;
  localparam act_t ACT_LT   = 3'd1;
  localparam act_t ACT_AMP  = 3'd2;
  localparam act_t ACT_GT   = 3'd3;
  localparam act_t ACT_QUOT = 3'd4;
  localparam act_t ACT_HEX  = 3'd5;

  // one transaction's worth of classified bytes
  typedef struct packed {
    logic [3:0][7:0] data;
    act_t [3:0]      act;
    logic [2:0]      cnt;
    logic            str_end;
  } tok_t;

  function automatic logic [2:0] esc_len(input act_t a);
    logic [2:0] n;
    unique case (a)
      ACT_BYTE: n = 3'd1;
      ACT_LT:   n = 3'd4;
      ACT_AMP:  n = 3'd5;
      ACT_GT:   n = 3'd4;
      ACT_QUOT: n = 3'd6;
      ACT_HEX:  n = 3'd4;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) d = 8'h30 + {4'd0, nib};
    else d = 8'h37 + {4'd0, nib};
    return d;
  endfunction

  function automatic logic [7:0] esc_char(input act_t a, input logic [7:0] b,
                                          input logic [2:0] idx);
    logic [7:0] ch;
    ch = b;
    unique case (a)
      ACT_LT: begin
        case (idx)
          3'd0: ch = "&";
          3'd1: ch = "l";
          3'd2: ch = "t";
          default: ch = ";";
        endcase
      end
      ACT_AMP: begin
        case (idx)
          3'd0: ch = "&";
          3'd1: ch = "a";
          3'd2: ch = "m";
          3'd3: ch = "p";
          default: ch = ";";
        endcase
      end
      ACT_GT: begin
        case (idx)
          3'd0: ch = "&";
          3'd1: ch = "g";
          3'd2: ch = "t";
          default: ch = ";";
        endcase
      end
      ACT_QUOT: begin
        case (idx)
          3'd0: ch = "&";
          3'd1: ch = "q";
          3'd2: ch = "u";
          3'd3: ch = "o";
          3'd4: ch = "t";
          default: ch = ";";
        endcase
      end
      ACT_HEX: begin
        case (idx)
          3'd0: ch = "\\";
          3'd1: ch = "x";
          3'd2: ch = hex_digit(b[7:4]);
          default: ch = hex_digit(b[3:0]);
        endcase
      end
      default: ch = b;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/xev_front.sv
// front end: utf-8 sequence holding, validation and per byte classification
module xev_front import xev_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       str_end,
  input  logic       attr,
  output logic       push,
  output tok_t       tok
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] tail_r [2];
  logic [7:0] tail_nxt [2];
  logic [2:0] seq_len_r, seq_len_nxt;
  logic [1:0] tail_cnt_r, tail_cnt_nxt;
  logic [7:0] rb0_r, rb0_nxt, rb1_r, rb1_nxt;
  logic [1:0] pc_r, pc_nxt;

  logic       held;
  logic [2:0] qn;
  logic [7:0] q [4];
  logic [7:0] rec0 [4];
  logic [7:0] rec1 [4];
  logic [3:0] pos_ok;
  act_t       act [4];
  logic [2:0] nxt_pos;
  logic       stop;
  logic [2:0] hold_pos;
  logic [2:0] hold_len;
  logic [2:0] cnt;
  logic [7:0] c, b1, b2, b3;
  logic [2:0] len, avail;
  logic       bad, complete, val_ok;
  logic [20:0] v;
  logic [2:0] psum;
  logic [2:0] pcs;
  logic [1:0] i1, i2;

  always_comb begin
    held = (seq_len_r != 3'd0);
    qn   = held ? (3'({1'b0, tail_cnt_r}) + 3'd2) : 3'd1;
    q[0] = held ? lead_r : in_byte;
    q[1] = (held && tail_cnt_r >= 2'd1) ? tail_r[0] : in_byte;
    q[2] = (held && tail_cnt_r >= 2'd2) ? tail_r[1] : in_byte;
    q[3] = in_byte;
    // raw bytes just before each slot
    rec0[0] = rb0_r; rec1[0] = rb1_r;
    rec0[1] = q[0];  rec1[1] = rb0_r;
    rec0[2] = q[1];  rec1[2] = q[0];
    rec0[3] = q[2];  rec1[3] = q[1];
    for (int p = 0; p < 4; p++) begin
      psum = 3'({1'b0, pc_r}) + 3'(p);
      pos_ok[p] = (psum >= 3'd3);
    end
  end

  always_comb begin
    nxt_pos  = 3'd0;
    stop     = 1'b0;
    hold_pos = 3'd0;
    hold_len = 3'd0;
    c = 8'd0; b1 = 8'd0; b2 = 8'd0; b3 = 8'd0;
    len = 3'd0; avail = 3'd0; bad = 1'b0; complete = 1'b0; val_ok = 1'b0;
    v = 21'd0;
    for (int p = 0; p < 4; p++) act[p] = ACT_BYTE;
    for (int p = 0; p < 4; p++) begin
      if (!stop && 3'(p) == nxt_pos && 3'(p) < qn) begin
        c = q[p];
        if (c >= 8'hC0 && c < 8'hF8) begin
          len   = (c < 8'hE0) ? 3'd2 : ((c < 8'hF0) ? 3'd3 : 3'd4);
          avail = qn - 3'(p) - 3'd1;
          b1 = q[2'(p + 1)];
          b2 = q[2'(p + 2)];
          b3 = q[2'(p + 3)];
          bad = 1'b0;
          if (avail >= 3'd1 && b1[7:6] != 2'b10) bad = 1'b1;
          if (avail >= 3'd2 && len >= 3'd3 && b2[7:6] != 2'b10) bad = 1'b1;
          if (avail >= 3'd3 && len >= 3'd4 && b3[7:6] != 2'b10) bad = 1'b1;
          complete = (avail >= len - 3'd1);
          if (len == 3'd2) begin
            v = {10'd0, c[4:0], b1[5:0]};
            val_ok = (v >= 21'h80);
          end else if (len == 3'd3) begin
            v = {5'd0, c[3:0], b1[5:0], b2[5:0]};
            val_ok = (v >= 21'h800);
          end else begin
            v = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
            val_ok = (v >= 21'h10000) && (v < 21'h110000);
          end
          if (!bad && complete && val_ok) begin
            nxt_pos = 3'(p) + len;
          end else if (!bad && !complete && !str_end) begin
            stop     = 1'b1;
            hold_pos = 3'(p);
            hold_len = len;
          end else begin
            act[p]  = ACT_HEX;
            nxt_pos = 3'(p) + 3'd1;
          end
        end else begin
          if (c == "<") act[p] = ACT_LT;
          else if (c == "&") act[p] = ACT_AMP;
          else if (c == ">") begin
            if (pos_ok[p] && rec0[p] == "]" && rec1[p] == "]") act[p] = ACT_GT;
          end else if (c == "\"") begin
            if (attr) act[p] = ACT_QUOT;
          end else if (c < 8'h09 || (c > 8'h0D && c < 8'h20) || c >= 8'h7F) begin
            act[p] = ACT_HEX;
          end
          nxt_pos = 3'(p) + 3'd1;
        end
      end
    end
    cnt = stop ? hold_pos : qn;
  end

  // next state after one accepted transaction
  always_comb begin
    lead_nxt     = lead_r;
    tail_nxt[0]  = tail_r[0];
    tail_nxt[1]  = tail_r[1];
    seq_len_nxt  = seq_len_r;
    tail_cnt_nxt = tail_cnt_r;
    rb0_nxt      = rb0_r;
    rb1_nxt      = rb1_r;
    pc_nxt       = pc_r;
    i1  = 2'(cnt - 3'd1);
    i2  = 2'(cnt - 3'd2);
    pcs = 3'({1'b0, pc_r}) + cnt;
    if (accept) begin
      if (stop) begin
        lead_nxt     = q[hold_pos[1:0]];
        tail_nxt[0]  = q[2'(hold_pos + 3'd1)];
        tail_nxt[1]  = q[2'(hold_pos + 3'd2)];
        seq_len_nxt  = hold_len;
        tail_cnt_nxt = 2'(qn - hold_pos - 3'd1);
      end else begin
        seq_len_nxt  = 3'd0;
        tail_cnt_nxt = 2'd0;
      end
      if (str_end) begin
        rb0_nxt = 8'd0;
        rb1_nxt = 8'd0;
        pc_nxt  = 2'd0;
      end else begin
        if (cnt == 3'd1) begin
          rb0_nxt = q[0];
          rb1_nxt = rb0_r;
        end else if (cnt >= 3'd2) begin
          rb0_nxt = q[i1];
          rb1_nxt = q[i2];
        end
        pc_nxt = (pcs >= 3'd3) ? 2'd3 : pcs[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r  <= 3'd0;
      tail_cnt_r <= 2'd0;
      rb0_r      <= 8'd0;
      rb1_r      <= 8'd0;
      pc_r       <= 2'd0;
    end else begin
      seq_len_r  <= seq_len_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      rb0_r      <= rb0_nxt;
      rb1_r      <= rb1_nxt;
      pc_r       <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r    <= lead_nxt;
    tail_r[0] <= tail_nxt[0];
    tail_r[1] <= tail_nxt[1];
  end

  always_comb begin
    push = accept && (cnt != 3'd0);
    for (int p = 0; p < 4; p++) begin
      tok.data[p] = q[p];
      tok.act[p]  = act[p];
    end
    tok.cnt     = cnt;
    tok.str_end = str_end;
  end

endmodule

>>> sv/xev_fifo.sv
// short token queue between front and back ends
module xev_fifo import xev_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t wdata,
  output logic full,
  input  logic pop,
  output tok_t head,
  output logic head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t            mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

endmodule

>>> sv/xev_back.sv
// back end: expands classified bytes into escaped output bytes
`include "xml_escape_utf8_validate_core_assert.svh"
module xev_back import xev_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tok_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic [1:0] pos_r, pos_nxt;
  logic [2:0] chr_r, chr_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r;
  logic       orl_r, osd_r;

  act_t       cur_act;
  logic [7:0] cur_byte;
  logic       load, last_chr, last_pos;

  always_comb begin
    cur_act  = head.act[pos_r];
    cur_byte = head.data[pos_r];
    load     = head_valid && (!ov_r || out_tready);
    last_chr = (chr_r == esc_len(cur_act) - 3'd1);
    last_pos = (3'({1'b0, pos_r}) == head.cnt - 3'd1);
    pop      = load && last_chr && last_pos;
    pos_nxt  = pos_r;
    chr_nxt  = chr_r;
    ov_nxt   = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
      if (last_chr) begin
        chr_nxt = 3'd0;
        pos_nxt = last_pos ? 2'd0 : pos_r + 2'd1;
      end else begin
        chr_nxt = chr_r + 3'd1;
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      chr_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      chr_r <= chr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r  <= esc_char(cur_act, cur_byte, chr_r);
      orl_r <= last_chr && last_pos;
      osd_r <= last_chr && last_pos && head.str_end;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = orl_r;
  assign out_tuser  = osd_r;

  `XEV_ASSERT_IMP(a_chr_range, clk, rst_n, head_valid, chr_r < esc_len(cur_act))
  `XEV_ASSERT_IMP(a_pos_range, clk, rst_n, head_valid, 3'(pos_r) < head.cnt)
  `XEV_ASSERT_NXT(a_pop_clears, clk, rst_n, pop, pos_r == 2'd0 && chr_r == 3'd0)

endmodule

>>> sv/xml_escape_utf8_validate_core.sv
// XML text escaper with UTF-8 validation. One raw byte enters per transaction
// (in_tlast marks the last byte of a string) and escaped bytes leave one per
// transaction, with out_tlast on the last byte caused by an input byte and
// out_tuser on the final byte of the string. The front end takes one input
// byte per cycle while the token queue is not full; a UTF-8 lead byte and its
// continuation bytes are held with no output until the sequence is complete,
// invalid or cut off by the string end. The back end sends one output byte per
// cycle while out_tready is high: a plain byte gives one output byte, an
// escape four to six, and one input byte may release up to three held bytes.
// So the input rate is one byte per cycle while the output keeps up, and
// otherwise it follows the output side, with a FIFO_DEPTH-entry token queue
// between the two ends, and the output byte is registered. The attribute_mode
// register on the cfg port enables &quot; escaping and is always ready.
module xml_escape_utf8_validate_core import xev_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser,  // [0] string_done
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic attr_r, attr_nxt;
  logic accept, push, full, pop, head_valid;
  tok_t tok, head;

  assign cfg_ready = 1'b1;
  assign attr_nxt  = (cfg_valid && cfg_ready) ? cfg_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= 1'b0;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  xev_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .str_end (in_tlast),
    .attr    (attr_r),
    .push    (push),
    .tok     (tok)
  );

  xev_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wdata      (tok),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  xev_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
